>>> rtl/core/lca_pkg.sv
// Package of shared types, codes and constants for the linear classifier argmax unit.
`timescale 1ns / 1ps

package lca_pkg;

  // Field widths fixed by the item format.
  localparam int OP_W     = 2;
  localparam int CLS_W    = 4;
  localparam int FIDX_W   = 10;
  localparam int VALUE_W  = 16;
  localparam int SCORE_W  = 48;
  localparam int PROD_W   = 2 * VALUE_W;
  localparam int CFG_W    = 11;
  localparam int CFG_IDX_W = 1;

  // Default sizes of the weight and bias stores.
  localparam int DEF_CLASSES  = 10;
  localparam int DEF_FEATURES = 1024;

  // Register values after reset.
  localparam int RST_CLASSES  = 10;
  localparam int RST_FEATURES = 514;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CLASSES  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FEATURES = 1'd1;

  // Saturation limits of a Q24.24 score.
  localparam logic signed [SCORE_W-1:0] SUM_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic signed [SCORE_W-1:0] SUM_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

  // Input operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_WEIGHT = 2'd0,
    OP_BIAS   = 2'd1,
    OP_SAMPLE = 2'd2
  } lca_op_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_BIAS,
    ST_OUT
  } lca_state_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic             mul_en;
    logic [CLS_W-1:0] mul_cls;
    logic             bias_en;
    logic [CLS_W-1:0] bias_cls;
    logic             first;
    logic             bias_we;
    logic [CLS_W-1:0] bias_widx;
    logic             clr;
  } lca_ctl_t;

endpackage

>>> rtl/core/linear_classifier_argmax_unit.sv
// Top level of the linear classifier argmax unit: sequencer, weight RAM and output register.
//
// Usage: input transactions carry an op code. A weight load writes one entry of the
// weight RAM, a bias load writes one class bias. A feature sample runs one shared
// multiplier over the classes in use, one class per cycle. The sample at the last
// position then adds each class bias through the same adder, picks the class of
// largest absolute score and loads the output register with that class and score.
// Throughput is set by the single multiply-accumulate unit and the one RAM read port.
// in_stall is high while a sample is being processed. A result waits in the output
// register while out_stall is high; new loads and samples are still taken, and only
// the next result, if one is ready, waits for the register to empty.
// Configuration writes through cfg_we/cfg_index/cfg_wdata take effect at once and
// must come while the block is idle. Synchronous reset clears the class sums, the
// control state and the output valid, and restores the default register values;
// weights and biases are undefined until loaded.
`timescale 1ns / 1ps

module linear_classifier_argmax_unit #(
  parameter int CLASSES  = lca_pkg::DEF_CLASSES,
  parameter int FEATURES = lca_pkg::DEF_FEATURES
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [lca_pkg::OP_W-1:0]            in_op,
  input  logic [lca_pkg::CLS_W-1:0]           in_class_index,
  input  logic [lca_pkg::FIDX_W-1:0]          in_feature_index,
  input  logic signed [lca_pkg::VALUE_W-1:0]  in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lca_pkg::CLS_W-1:0]           out_predicted_class,
  output logic signed [lca_pkg::SCORE_W-1:0]  out_best_score,
  input  logic                                cfg_we,
  input  logic [lca_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lca_pkg::CFG_W-1:0]           cfg_wdata
);

  import lca_pkg::*;

  localparam int IW      = $clog2(CLASSES);
  localparam int CW      = $clog2(CLASSES + 1);
  localparam int FW      = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int NW      = $clog2(FEATURES + 1);
  localparam int DEPTH   = CLASSES * (2 ** FW);
  localparam int CLS_RST = (RST_CLASSES > CLASSES) ? CLASSES : RST_CLASSES;
  localparam int FEA_RST = (RST_FEATURES > FEATURES) ? FEATURES : RST_FEATURES;

  lca_state_t state_r, state_nxt;

  logic [CW-1:0]             cls_n_r;
  logic [NW-1:0]             feat_n_r;
  logic [CW-1:0]             cls_cfg;
  logic [NW-1:0]             feat_cfg;
  logic [3:0]                cfg_cls_raw;

  logic [CW-1:0]             issue_r, issue_nxt;
  logic                      rd_v_r, rd_v_nxt;
  logic [IW-1:0]             rd_cls_r;
  logic signed [VALUE_W-1:0] val_r, val_nxt;
  logic [FW-1:0]             feat_r, feat_nxt;
  logic                      last_r, last_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [CLS_W-1:0]          out_cls_r;
  logic signed [SCORE_W-1:0] out_score_r;
  logic                      out_load;

  logic                      in_acc;
  logic                      issue_act;
  logic                      ram_we;
  logic [IW+FW-1:0]          ram_addr;
  logic signed [VALUE_W-1:0] ram_rdata;

  lca_ctl_t                  ctl;
  logic [CLS_W-1:0]          dp_best_cls;
  logic signed [SCORE_W-1:0] dp_best_score;
  logic                      dp_busy;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign issue_act = (issue_r < cls_n_r);

  // Configuration values are stored already clamped to the supported range.
  always_comb begin
    cfg_cls_raw = cfg_wdata[3:0];
    if (cfg_cls_raw == '0) begin
      cls_cfg = CW'(1);
    end else if (32'(cfg_cls_raw) > CLASSES) begin
      cls_cfg = CW'(CLASSES);
    end else begin
      cls_cfg = CW'(cfg_cls_raw);
    end
    if (cfg_wdata == '0) begin
      feat_cfg = NW'(1);
    end else if (32'(cfg_wdata) > FEATURES) begin
      feat_cfg = NW'(FEATURES);
    end else begin
      feat_cfg = NW'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_n_r  <= CW'(CLS_RST);
      feat_n_r <= NW'(FEA_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CLASSES:  cls_n_r  <= cls_cfg;
        CFG_FEATURES: feat_n_r <= feat_cfg;
        default: ;
      endcase
    end
  end

  // Weight RAM shares its port between loads in idle and reads while scoring.
  always_comb begin
    if (state_r == ST_IDLE) begin
      ram_addr = {in_class_index[IW-1:0], FW'(in_feature_index)};
    end else begin
      ram_addr = {issue_r[IW-1:0], feat_r};
    end
  end

  lca_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_weight_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_value),
    .rdata (ram_rdata)
  );

  lca_datapath #(
    .CLASSES (CLASSES)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .weight     (ram_rdata),
    .sample     (val_r),
    .bias_wdata (in_value),
    .best_cls   (dp_best_cls),
    .best_score (dp_best_score),
    .busy       (dp_busy)
  );

  // Sequencer state and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issue_r     <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issue_r     <= issue_nxt;
      rd_v_r      <= rd_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers of the current sample and of the result.
  always_ff @(posedge clk) begin
    val_r    <= val_nxt;
    feat_r   <= feat_nxt;
    last_r   <= last_nxt;
    rd_cls_r <= issue_r[IW-1:0];
    if (out_load) begin
      out_cls_r   <= dp_best_cls;
      out_score_r <= dp_best_score;
    end
  end

  // Next state and datapath control.
  always_comb begin
    state_nxt     = state_r;
    issue_nxt     = issue_r;
    rd_v_nxt      = 1'b0;
    val_nxt       = val_r;
    feat_nxt      = feat_r;
    last_nxt      = last_r;
    out_load      = 1'b0;
    ram_we        = 1'b0;
    ctl           = '0;
    ctl.mul_en    = rd_v_r;
    ctl.mul_cls   = CLS_W'(rd_cls_r);
    ctl.bias_widx = in_class_index;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (lca_op_t'(in_op))
            OP_WEIGHT: begin
              ram_we = (32'(in_class_index) < CLASSES) && (32'(in_feature_index) < FEATURES);
            end
            OP_BIAS: begin
              ctl.bias_we = (32'(in_class_index) < CLASSES);
            end
            OP_SAMPLE: begin
              if (32'(in_feature_index) < 32'(feat_n_r)) begin
                val_nxt   = in_value;
                feat_nxt  = FW'(in_feature_index);
                last_nxt  = (32'(in_feature_index) == 32'(feat_n_r) - 1);
                issue_nxt = '0;
                state_nxt = ST_MAC;
              end
            end
            default: ;
          endcase
        end
      end

      ST_MAC: begin
        // Issue one weight read per class, then let the pipeline drain.
        if (issue_act) begin
          rd_v_nxt  = 1'b1;
          issue_nxt = issue_r + 1'b1;
        end else if (!rd_v_r && !dp_busy) begin
          issue_nxt = '0;
          state_nxt = last_r ? ST_BIAS : ST_IDLE;
        end
      end

      ST_BIAS: begin
        ctl.bias_en  = 1'b1;
        ctl.bias_cls = CLS_W'(issue_r[IW-1:0]);
        ctl.first    = (issue_r == '0);
        issue_nxt    = issue_r + 1'b1;
        if (issue_r == cls_n_r - 1'b1) begin
          issue_nxt = '0;
          state_nxt = ST_OUT;
        end
      end

      ST_OUT: begin
        // Wait for the last compare and a free output register.
        if (!dp_busy && (!out_valid_r || !out_stall)) begin
          out_load  = 1'b1;
          ctl.clr   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_predicted_class = out_cls_r;
  assign out_best_score      = out_score_r;

`ifndef NO_ASSERTIONS
  // The scoring pass ends only with the multiply pipeline empty.
  a_mac_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAC && state_nxt != ST_MAC) |-> (!rd_v_r && !dp_busy))
    else $error("scoring pass left with products in flight");

  // A new result appears only out of the result state.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result valid rose outside the result state");

  // The class counter never runs past the classes in use.
  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    issue_r <= cls_n_r)
    else $error("class counter beyond classes in use");

  // The stored class count stays within the supported range.
  a_cls_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cls_n_r != '0) && (32'(cls_n_r) <= CLASSES))
    else $error("class count out of range");
`endif

endmodule

>>> rtl/core/lca_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module lca_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write on enable, read every cycle into the output register.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/lca_datapath.sv
// Shared multiplier, saturating adder, class sums, bias store and argmax tracker.
`timescale 1ns / 1ps

module lca_datapath #(
  parameter int CLASSES = lca_pkg::DEF_CLASSES
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lca_pkg::lca_ctl_t                   ctl,
  input  logic signed [lca_pkg::VALUE_W-1:0]  weight,
  input  logic signed [lca_pkg::VALUE_W-1:0]  sample,
  input  logic signed [lca_pkg::VALUE_W-1:0]  bias_wdata,
  output logic [lca_pkg::CLS_W-1:0]           best_cls,
  output logic signed [lca_pkg::SCORE_W-1:0]  best_score,
  output logic                                busy
);

  import lca_pkg::*;

  localparam int IW = $clog2(CLASSES);

  logic signed [SCORE_W-1:0] sums_r [CLASSES];
  logic signed [VALUE_W-1:0] bias_r [CLASSES];

  logic signed [PROD_W-1:0]  prod_r;
  logic [IW-1:0]             prod_cls_r;
  logic                      prod_v_r;

  logic signed [SCORE_W-1:0] s_r;
  logic [IW-1:0]             s_cls_r;
  logic                      s_first_r;
  logic                      s_v_r;

  logic [SCORE_W-1:0]        best_abs_r;
  logic signed [SCORE_W-1:0] best_score_r;
  logic [IW-1:0]             best_cls_r;

  logic [IW-1:0]             sel_idx;
  logic signed [VALUE_W-1:0] sel_bias;
  logic signed [SCORE_W-1:0] addend;
  logic signed [SCORE_W:0]   sum_wide;
  logic signed [SCORE_W-1:0] sum_sat;
  logic [SCORE_W-1:0]        s_abs;
  logic                      take;

  // One adder serves both the accumulation and the bias addition.
  always_comb begin
    sel_idx  = prod_v_r ? prod_cls_r : ctl.bias_cls[IW-1:0];
    sel_bias = bias_r[sel_idx];
    if (prod_v_r) begin
      addend = {{(SCORE_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end else begin
      addend = {{(SCORE_W-VALUE_W-12){sel_bias[VALUE_W-1]}}, sel_bias, 12'b0};
    end
    sum_wide = {sums_r[sel_idx][SCORE_W-1], sums_r[sel_idx]} + {addend[SCORE_W-1], addend};
    if (sum_wide[SCORE_W] != sum_wide[SCORE_W-1]) begin
      sum_sat = sum_wide[SCORE_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_wide[SCORE_W-1:0];
    end
  end

  // Magnitude compare of the biased score against the best so far.
  always_comb begin
    s_abs = s_r[SCORE_W-1] ? (~s_r + 1'b1) : s_r;
    take  = s_v_r && (s_first_r || (s_abs > best_abs_r));
  end

  // Pipeline valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
      s_v_r    <= 1'b0;
    end else begin
      prod_v_r <= ctl.mul_en;
      s_v_r    <= ctl.bias_en;
    end
  end

  // Product stage and biased score stage.
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r     <= weight * sample;
      prod_cls_r <= ctl.mul_cls[IW-1:0];
    end
    if (ctl.bias_en) begin
      s_r       <= sum_sat;
      s_cls_r   <= ctl.bias_cls[IW-1:0];
      s_first_r <= ctl.first;
    end
    if (take) begin
      best_abs_r   <= s_abs;
      best_score_r <= s_r;
      best_cls_r   <= s_cls_r;
    end
  end

  // Class sums clear at reset and after every result.
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      for (int i = 0; i < CLASSES; i++) begin
        sums_r[i] <= '0;
      end
    end else if (prod_v_r) begin
      sums_r[prod_cls_r] <= sum_sat;
    end
  end

  // Bias store holds what was loaded.
  always_ff @(posedge clk) begin
    if (ctl.bias_we) begin
      bias_r[ctl.bias_widx[IW-1:0]] <= bias_wdata;
    end
  end

  assign best_cls   = CLS_W'(best_cls_r);
  assign best_score = best_score_r;
  assign busy       = prod_v_r | s_v_r;

endmodule
